### rtl/mdmp_pkg.sv
// Package: shared types and constants of the motion delta mode processor.
`timescale 1ns / 1ps
package mdmp_pkg;

  localparam int DELTA_BITS_DEF = 12;
  localparam int MAG_W          = 16;
  localparam int DIV_STEPS      = 2;
  localparam int DIV_CYC        = MAG_W / DIV_STEPS;
  localparam int CNT_W          = $clog2(DIV_CYC);
  localparam int MUL_LAST       = 3;
  localparam int TICK_W         = 12;
  localparam int CFG_W          = 12;

  localparam logic signed [15:0] COS45_Q15 = 16'sd23170;

  localparam logic [8:0] ANG_0   = 9'd0;
  localparam logic [8:0] ANG_45  = 9'd45;
  localparam logic [8:0] ANG_90  = 9'd90;
  localparam logic [8:0] ANG_135 = 9'd135;
  localparam logic [8:0] ANG_180 = 9'd180;
  localparam logic [8:0] ANG_225 = 9'd225;
  localparam logic [8:0] ANG_270 = 9'd270;
  localparam logic [8:0] ANG_315 = 9'd315;
  localparam logic [8:0] ANG_360 = 9'd360;

  localparam logic [7:0] NIB_HI = 8'hF0;
  localparam logic [7:0] NIB_LO = 8'h0F;

  localparam logic [1:0] MODE_MOVE   = 2'd0;
  localparam logic [1:0] MODE_SCROLL = 2'd1;
  localparam logic [1:0] MODE_SNIPE  = 2'd2;
  localparam logic [1:0] MODE_BALL   = 2'd3;

  localparam logic [2:0] RK_NONE   = 3'd0;
  localparam logic [2:0] RK_MOVE   = 3'd1;
  localparam logic [2:0] RK_WHEEL  = 3'd2;
  localparam logic [2:0] RK_HWHEEL = 3'd3;
  localparam logic [2:0] RK_BALL   = 3'd4;

  localparam logic [1:0] DIR_XPOS = 2'd0;
  localparam logic [1:0] DIR_XNEG = 2'd1;
  localparam logic [1:0] DIR_YNEG = 2'd2;
  localparam logic [1:0] DIR_YPOS = 2'd3;

  localparam logic signed [1:0] STEP_UP   = 2'sb01;
  localparam logic signed [1:0] STEP_DOWN = 2'sb11;

  localparam logic [2:0] CFG_MOVE_DIV   = 3'd0;
  localparam logic [2:0] CFG_SNIPE_DIV  = 3'd1;
  localparam logic [2:0] CFG_BASE_ORIENT = 3'd2;
  localparam logic [2:0] CFG_EXTRA_ROT  = 3'd3;
  localparam logic [2:0] CFG_INV_X      = 3'd4;
  localparam logic [2:0] CFG_INV_Y      = 3'd5;
  localparam logic [2:0] CFG_SCROLL_TICK = 3'd6;
  localparam logic [2:0] CFG_BALL_TICK  = 3'd7;

  localparam logic [1:0] ORI_0   = 2'd0;
  localparam logic [1:0] ORI_90  = 2'd1;
  localparam logic [1:0] ORI_180 = 2'd2;
  localparam logic [1:0] ORI_270 = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_X,
    ST_DIV_Y,
    ST_ROT,
    ST_MUL,
    ST_CLIP,
    ST_EMIT
  } state_t;

endpackage

### rtl/motion_delta_mode_processor_core.sv
// Top level: motion burst to pointer, scroll or ball action transaction.
// Steps: the X and Y quotients, a rotate, then for a 45-degree rotation a multiply and a clip,
// and last an emit of the result.
// A new transaction is taken only after the last result is emitted; a stalled result holds it back.
// Reset: synchronous active-low rst_n clears the sequencer, accumulators and result
// valid and returns the registers to their defaults.
`timescale 1ns / 1ps
module motion_delta_mode_processor_core
  import mdmp_pkg::*;
#(
  parameter int DELTA_BITS = DELTA_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_x_low,
  input  logic [7:0]              in_y_low,
  input  logic [7:0]              in_xy_high,
  input  logic [1:0]              in_mode,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [2:0]              out_report_kind,
  output logic signed [15:0]      out_move_x,
  output logic signed [15:0]      out_move_y,
  output logic signed [1:0]       out_wheel_step,
  output logic [1:0]              out_action_dir,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [2:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  state_t state_r, state_nxt;

  logic [7:0]              move_div_r, snipe_div_r;
  logic [1:0]              orient_r;
  logic [8:0]              rot_r;
  logic                    inv_x_r, inv_y_r;
  logic [TICK_W-1:0]       scroll_tick_r, ball_tick_r;

  logic signed [15:0]      sacc_x_r, sacc_y_r, bacc_x_r, bacc_y_r;
  logic signed [15:0]      sacc_x_nxt, sacc_y_nxt, bacc_x_nxt, bacc_y_nxt;
  logic [1:0]              last_mode_r;

  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [7:0]              rem_r, rem_nxt;
  logic [MAG_W-1:0]        quo_r, quo_nxt;
  logic [7:0]              div_r, div_nxt;
  logic                    xneg_r, xneg_nxt, yneg_r, yneg_nxt;
  logic [MAG_W-1:0]        ymag_r, ymag_nxt;
  logic [1:0]              mode_r, mode_nxt;
  logic signed [15:0]      rx_r, rx_nxt, ry_r, ry_nxt;
  logic signed [15:0]      x_r, x_nxt, y_r, y_nxt;
  logic                    cneg_r, cneg_nxt, sneg_r, sneg_nxt;
  logic signed [17:0]      ax_r, ax_nxt, ay_r, ay_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [2:0]              kind_r;
  logic signed [15:0]      mx_r, my_r;
  logic signed [1:0]       step_r;
  logic [1:0]              dir_r;

  logic                    in_fire, emit_ok, emit_fire;
  logic                    div_last, mul_last, rot45;
  logic [8:0]              rot_ang;

  logic [15:0]             raw_x, raw_y;
  logic signed [DELTA_BITS-1:0] dx, dy;
  logic signed [16:0]      sx, sy;
  logic [7:0]              div_sel;

  logic [7:0]              t_rem;
  logic [MAG_W-1:0]        t_quo;
  logic [8:0]              t_sh;
  logic signed [15:0]      q_signed;

  logic signed [15:0]      bx, by;
  logic signed [15:0]      mul_a, mul_b;
  logic signed [31:0]      prod;
  logic signed [16:0]      prod_q;

  logic signed [15:0]      xi, yi;
  logic                    nz, changed;
  logic signed [15:0]      sbx, sby, bbx, bby;
  logic signed [15:0]      snx, sny, bnx, bny;
  logic [2:0]              kind_e;
  logic signed [15:0]      mx_e, my_e;
  logic signed [1:0]       step_e;
  logic [1:0]              dir_e;

  function automatic logic [16:0] mag17(input logic signed [15:0] v);
    logic signed [16:0] w;
    w = 17'(v);
    return (w < 0) ? 17'(-w) : 17'(w);
  endfunction

  function automatic logic signed [15:0] clip16(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  assign in_fire   = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE) && !in_valid;
  assign emit_ok   = !out_valid_r || !out_stall;
  assign emit_fire = (state_r == ST_EMIT) && emit_ok;
  assign div_last  = (cnt_r == CNT_W'(DIV_CYC - 1));
  assign mul_last  = (cnt_r == CNT_W'(MUL_LAST));
  assign rot_ang   = (rot_r >= ANG_360) ? 9'(rot_r - ANG_360) : rot_r;
  assign rot45     = (rot_ang == ANG_45) || (rot_ang == ANG_135) ||
                     (rot_ang == ANG_225) || (rot_ang == ANG_315);

  assign raw_x = {4'b0, 4'((in_xy_high & NIB_HI) >> 4), in_x_low};
  assign raw_y = {4'b0, 4'(in_xy_high & NIB_LO), in_y_low};
  assign dx    = raw_x[DELTA_BITS-1:0];
  assign dy    = raw_y[DELTA_BITS-1:0];
  assign sx    = 17'(dx);
  assign sy    = 17'(dy);

  always_comb begin
    div_sel = 8'd1;
    if (in_mode == MODE_MOVE) begin
      div_sel = move_div_r;
    end else if (in_mode == MODE_SNIPE) begin
      div_sel = snipe_div_r;
    end
    if (div_sel == 8'd0) begin
      div_sel = 8'd1;
    end
  end

  always_comb begin
    t_rem = rem_r;
    t_quo = quo_r;
    t_sh  = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t_sh  = {t_rem, t_quo[MAG_W-1]};
      t_quo = {t_quo[MAG_W-2:0], 1'b0};
      if (t_sh >= {1'b0, div_r}) begin
        t_rem    = 8'(t_sh - {1'b0, div_r});
        t_quo[0] = 1'b1;
      end else begin
        t_rem = t_sh[7:0];
      end
    end
  end

  always_comb begin
    q_signed = ((state_r == ST_DIV_X) ? xneg_r : yneg_r) ? 16'(-t_quo) : 16'(t_quo);
  end

  always_comb begin
    unique case (orient_r)
      ORI_0: begin
        bx = -rx_r;
        by = ry_r;
      end
      ORI_90: begin
        bx = ry_r;
        by = -rx_r;
      end
      ORI_180: begin
        bx = rx_r;
        by = -ry_r;
      end
      ORI_270: begin
        bx = -ry_r;
        by = rx_r;
      end
      default: begin
        bx = rx_r;
        by = ry_r;
      end
    endcase
  end

  always_comb begin
    mul_a = cnt_r[0] ? y_r : x_r;
    if (cnt_r[1] ^ cnt_r[0]) begin
      mul_b = sneg_r ? -COS45_Q15 : COS45_Q15;
    end else begin
      mul_b = cneg_r ? -COS45_Q15 : COS45_Q15;
    end
    prod   = mul_a * mul_b;
    prod_q = prod[31:15];
  end

  always_comb begin
    xi      = inv_x_r ? -x_r : x_r;
    yi      = inv_y_r ? -y_r : y_r;
    nz      = (xi != 16'sd0) || (yi != 16'sd0);
    changed = (mode_r != last_mode_r);
    sbx     = (mode_r == MODE_SCROLL && changed) ? 16'sd0 : sacc_x_r;
    sby     = (mode_r == MODE_SCROLL && changed) ? 16'sd0 : sacc_y_r;
    bbx     = (mode_r == MODE_BALL && changed) ? 16'sd0 : bacc_x_r;
    bby     = (mode_r == MODE_BALL && changed) ? 16'sd0 : bacc_y_r;
    snx     = sbx + xi;
    sny     = sby + yi;
    bnx     = bbx + xi;
    bny     = bby + yi;
    kind_e  = RK_NONE;
    mx_e    = '0;
    my_e    = '0;
    step_e  = '0;
    dir_e   = DIR_XPOS;
    sacc_x_nxt = sbx;
    sacc_y_nxt = sby;
    bacc_x_nxt = bbx;
    bacc_y_nxt = bby;
    if (nz) begin
      case (mode_r) inside
        MODE_MOVE, MODE_SNIPE: begin
          kind_e = RK_MOVE;
          mx_e   = xi;
          my_e   = yi;
        end
        MODE_SCROLL: begin
          sacc_x_nxt = snx;
          sacc_y_nxt = sny;
          if (mag17(sny) > 17'(scroll_tick_r)) begin
            kind_e = RK_WHEEL;
            step_e = (sny > 16'sd0) ? STEP_DOWN : STEP_UP;
          end else if (mag17(snx) > 17'(scroll_tick_r)) begin
            kind_e = RK_HWHEEL;
            step_e = (snx > 16'sd0) ? STEP_DOWN : STEP_UP;
          end
          if (kind_e != RK_NONE) begin
            sacc_x_nxt = '0;
            sacc_y_nxt = '0;
          end
        end
        default: begin
          bacc_x_nxt = bnx;
          bacc_y_nxt = bny;
          if (mag17(bnx) > 17'(ball_tick_r)) begin
            kind_e = RK_BALL;
            dir_e  = (bnx > 16'sd0) ? DIR_XPOS : DIR_XNEG;
          end else if (mag17(bny) > 17'(ball_tick_r)) begin
            kind_e = RK_BALL;
            dir_e  = (bny > 16'sd0) ? DIR_YPOS : DIR_YNEG;
          end
          if (kind_e != RK_NONE) begin
            bacc_x_nxt = '0;
            bacc_y_nxt = '0;
          end
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = ST_DIV_X;
      ST_DIV_X: if (div_last) state_nxt = ST_DIV_Y;
      ST_DIV_Y: if (div_last) state_nxt = ST_ROT;
      ST_ROT:   state_nxt = rot45 ? ST_MUL : ST_EMIT;
      ST_MUL:   if (mul_last) state_nxt = ST_CLIP;
      ST_CLIP:  state_nxt = ST_EMIT;
      ST_EMIT:  if (emit_ok) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    xneg_nxt = xneg_r;
    yneg_nxt = yneg_r;
    ymag_nxt = ymag_r;
    mode_nxt = mode_r;
    rx_nxt   = rx_r;
    ry_nxt   = ry_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    cneg_nxt = cneg_r;
    sneg_nxt = sneg_r;
    ax_nxt   = ax_r;
    ay_nxt   = ay_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cnt_nxt  = '0;
          rem_nxt  = '0;
          quo_nxt  = (sx < 0) ? MAG_W'(-sx) : MAG_W'(sx);
          ymag_nxt = (sy < 0) ? MAG_W'(-sy) : MAG_W'(sy);
          xneg_nxt = (sx < 0);
          yneg_nxt = (sy < 0);
          div_nxt  = div_sel;
          mode_nxt = in_mode;
        end
      end
      ST_DIV_X: begin
        cnt_nxt = cnt_r + 1'b1;
        rem_nxt = t_rem;
        quo_nxt = t_quo;
        if (div_last) begin
          rx_nxt  = q_signed;
          rem_nxt = '0;
          quo_nxt = ymag_r;
        end
      end
      ST_DIV_Y: begin
        cnt_nxt = cnt_r + 1'b1;
        rem_nxt = t_rem;
        quo_nxt = t_quo;
        if (div_last) begin
          ry_nxt = q_signed;
        end
      end
      ST_ROT: begin
        cnt_nxt  = '0;
        cneg_nxt = (rot_ang == ANG_135) || (rot_ang == ANG_225);
        sneg_nxt = (rot_ang == ANG_225) || (rot_ang == ANG_315);
        if (rot_ang == ANG_90) begin
          x_nxt = -by;
          y_nxt = bx;
        end else if (rot_ang == ANG_180) begin
          x_nxt = -bx;
          y_nxt = -by;
        end else if (rot_ang == ANG_270) begin
          x_nxt = by;
          y_nxt = -bx;
        end else begin
          x_nxt = bx;
          y_nxt = by;
        end
      end
      ST_MUL: begin
        cnt_nxt = cnt_r + 1'b1;
        case (cnt_r[1:0])
          2'd0:    ax_nxt = 18'(prod_q);
          2'd1:    ax_nxt = ax_r - 18'(prod_q);
          2'd2:    ay_nxt = 18'(prod_q);
          default: ay_nxt = ay_r + 18'(prod_q);
        endcase
      end
      ST_CLIP: begin
        x_nxt = clip16(ax_r);
        y_nxt = clip16(ay_r);
      end
      ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      move_div_r    <= 8'd1;
      snipe_div_r   <= 8'd1;
      orient_r      <= ORI_0;
      rot_r         <= ANG_0;
      inv_x_r       <= 1'b0;
      inv_y_r       <= 1'b0;
      scroll_tick_r <= TICK_W'(20);
      ball_tick_r   <= TICK_W'(20);
      sacc_x_r      <= '0;
      sacc_y_r      <= '0;
      bacc_x_r      <= '0;
      bacc_y_r      <= '0;
      last_mode_r   <= MODE_MOVE;
      cnt_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_MOVE_DIV:    move_div_r    <= cfg_data[7:0];
          CFG_SNIPE_DIV:   snipe_div_r   <= cfg_data[7:0];
          CFG_BASE_ORIENT: orient_r      <= cfg_data[1:0];
          CFG_EXTRA_ROT:   rot_r         <= cfg_data[8:0];
          CFG_INV_X:       inv_x_r       <= cfg_data[0];
          CFG_INV_Y:       inv_y_r       <= cfg_data[0];
          CFG_SCROLL_TICK: scroll_tick_r <= cfg_data[TICK_W-1:0];
          CFG_BALL_TICK:   ball_tick_r   <= cfg_data[TICK_W-1:0];
          default: begin
          end
        endcase
      end
      if (emit_fire) begin
        sacc_x_r    <= sacc_x_nxt;
        sacc_y_r    <= sacc_y_nxt;
        bacc_x_r    <= bacc_x_nxt;
        bacc_y_r    <= bacc_y_nxt;
        last_mode_r <= mode_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    div_r  <= div_nxt;
    xneg_r <= xneg_nxt;
    yneg_r <= yneg_nxt;
    ymag_r <= ymag_nxt;
    mode_r <= mode_nxt;
    rx_r   <= rx_nxt;
    ry_r   <= ry_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    cneg_r <= cneg_nxt;
    sneg_r <= sneg_nxt;
    ax_r   <= ax_nxt;
    ay_r   <= ay_nxt;
    if (emit_fire) begin
      kind_r <= kind_e;
      mx_r   <= mx_e;
      my_r   <= my_e;
      step_r <= step_e;
      dir_r  <= dir_e;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_report_kind = kind_r;
  assign out_move_x      = mx_r;
  assign out_move_y      = my_r;
  assign out_wheel_step  = step_r;
  assign out_action_dir  = dir_r;

`ifndef SYNTH
  a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_DIV_X)
    else $error("transaction accepted without starting the quotient");

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_X || state_r == ST_DIV_Y) |-> rem_r < div_r)
    else $error("divider remainder not below divisor");

  a_move_fields_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_report_kind != RK_MOVE) |-> (out_move_x == 16'sd0 && out_move_y == 16'sd0))
    else $error("move deltas set on a non-move result");

  a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_valid_r && out_stall) |=> state_r == ST_EMIT)
    else $error("result dropped while output held");
`endif

endmodule

### test/tb_top.sv
// Testbench for the motion delta mode processor: predicted reports checked against the core.
`timescale 1ns / 1ps
module tb_top;
  import mdmp_pkg::*;

  localparam int SETTLE_CYC   = 40;
  localparam int WATCHDOG_MAX = 5000;
  localparam int HOLD_LEN     = 400;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [15:0] mx;
    logic signed [15:0] my;
    logic signed [1:0]  step;
    logic [1:0]         dir;
  } report_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [7:0]               in_x_low = '0;
  logic [7:0]               in_y_low = '0;
  logic [7:0]               in_xy_high = '0;
  logic [1:0]               in_mode = MODE_MOVE;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [2:0]               out_report_kind;
  logic signed [15:0]       out_move_x;
  logic signed [15:0]       out_move_y;
  logic signed [1:0]        out_wheel_step;
  logic [1:0]               out_action_dir;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [2:0]               cfg_index = CFG_MOVE_DIV;
  logic [CFG_W-1:0]         cfg_data = '0;

  // predictor copy of the registers and accumulators
  logic [7:0]  div_move = 8'd1;
  logic [7:0]  div_snipe = 8'd1;
  logic [1:0]  mount_ori = ORI_0;
  logic [8:0]  turn_deg = ANG_0;
  logic        flip_x = 1'b0;
  logic        flip_y = 1'b0;
  logic [11:0] wheel_thresh = 12'd20;
  logic [11:0] ball_thresh = 12'd20;
  int          wheel_sum_x = 0;
  int          wheel_sum_y = 0;
  int          ball_sum_x = 0;
  int          ball_sum_y = 0;
  logic [1:0]  prev_mode = MODE_MOVE;

  report_t     pending_reports[$];
  int          fail_count = 0;
  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;
  int          hold_request = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;

  always #1 clk = ~clk;

  motion_delta_mode_processor_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_x_low        (in_x_low),
    .in_y_low        (in_y_low),
    .in_xy_high      (in_xy_high),
    .in_mode         (in_mode),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_report_kind (out_report_kind),
    .out_move_x      (out_move_x),
    .out_move_y      (out_move_y),
    .out_wheel_step  (out_wheel_step),
    .out_action_dir  (out_action_dir),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  function automatic int wrap16(input int v);
    logic signed [15:0] w;
    w = v[15:0];
    return int'(w);
  endfunction

  function automatic int clamp16(input int v);
    return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
  endfunction

  function automatic int abs_of(input int v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic predict_report(input logic [7:0] xl, input logic [7:0] yl,
                                input logic [7:0] xyh, input logic [1:0] md,
                                output report_t rep);
    int         divisor;
    int         rx;
    int         ry;
    int         x;
    int         y;
    int         t;
    int         c;
    int         s;
    logic [8:0] ang;
    rep = '0;
    divisor = 1;
    if (md == MODE_MOVE) divisor = int'(div_move);
    else if (md == MODE_SNIPE) divisor = int'(div_snipe);
    if (divisor == 0) divisor = 1;
    if (md != prev_mode && md == MODE_SCROLL) begin
      wheel_sum_x = 0;
      wheel_sum_y = 0;
    end
    if (md != prev_mode && md == MODE_BALL) begin
      ball_sum_x = 0;
      ball_sum_y = 0;
    end
    prev_mode = md;

    rx = int'($signed({xyh[7:4], xl}));
    ry = int'($signed({xyh[3:0], yl}));
    rx = rx / divisor;
    ry = ry / divisor;

    case (mount_ori)
      ORI_0: begin
        x = wrap16(-rx);
        y = ry;
      end
      ORI_90: begin
        x = ry;
        y = wrap16(-rx);
      end
      ORI_180: begin
        x = rx;
        y = wrap16(-ry);
      end
      default: begin
        x = wrap16(-ry);
        y = rx;
      end
    endcase

    ang = turn_deg % ANG_360;
    if (ang == ANG_90) begin
      t = wrap16(-y);
      y = x;
      x = t;
    end else if (ang == ANG_180) begin
      x = wrap16(-x);
      y = wrap16(-y);
    end else if (ang == ANG_270) begin
      t = y;
      y = wrap16(-x);
      x = t;
    end else if (ang != ANG_0 && (ang % ANG_45) == ANG_0) begin
      c = int'(COS45_Q15);
      s = int'(COS45_Q15);
      if (ang == ANG_135 || ang == ANG_225) c = -c;
      if (ang == ANG_225 || ang == ANG_315) s = -s;
      t = clamp16(((x * c) >>> 15) - ((y * s) >>> 15));
      y = clamp16(((x * s) >>> 15) + ((y * c) >>> 15));
      x = t;
    end

    if (flip_x) x = wrap16(-x);
    if (flip_y) y = wrap16(-y);

    if (x != 0 || y != 0) begin
      case (md) inside
        MODE_MOVE, MODE_SNIPE: begin
          rep.kind = RK_MOVE;
          rep.mx = x[15:0];
          rep.my = y[15:0];
        end
        MODE_SCROLL: begin
          wheel_sum_x = wrap16(wheel_sum_x + x);
          wheel_sum_y = wrap16(wheel_sum_y + y);
          if (abs_of(wheel_sum_y) > int'(wheel_thresh)) begin
            rep.kind = RK_WHEEL;
            rep.step = (wheel_sum_y > 0) ? STEP_DOWN : STEP_UP;
          end else if (abs_of(wheel_sum_x) > int'(wheel_thresh)) begin
            rep.kind = RK_HWHEEL;
            rep.step = (wheel_sum_x > 0) ? STEP_DOWN : STEP_UP;
          end
          if (rep.kind != RK_NONE) begin
            wheel_sum_x = 0;
            wheel_sum_y = 0;
          end
        end
        default: begin
          ball_sum_x = wrap16(ball_sum_x + x);
          ball_sum_y = wrap16(ball_sum_y + y);
          if (abs_of(ball_sum_x) > int'(ball_thresh)) begin
            rep.kind = RK_BALL;
            rep.dir = (ball_sum_x > 0) ? DIR_XPOS : DIR_XNEG;
          end else if (abs_of(ball_sum_y) > int'(ball_thresh)) begin
            rep.kind = RK_BALL;
            rep.dir = (ball_sum_y > 0) ? DIR_YPOS : DIR_YNEG;
          end
          if (rep.kind != RK_NONE) begin
            ball_sum_x = 0;
            ball_sum_y = 0;
          end
        end
      endcase
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $error("report_kind: expected no transaction, got %0d", out_report_kind);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("report_kind", int'(want.kind), int'(out_report_kind));
        check_field("move_x", int'($signed(want.mx)), int'(out_move_x));
        check_field("move_y", int'($signed(want.my)), int'(out_move_y));
        check_field("wheel_step", int'($signed(want.step)), int'(out_wheel_step));
        check_field("action_dir", int'(want.dir), int'(out_action_dir));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_MAX) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  task automatic send_burst(input logic [7:0] xl, input logic [7:0] yl,
                            input logic [7:0] xyh, input logic [1:0] md);
    report_t rep;
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_x_low   <= xl;
    in_y_low   <= yl;
    in_xy_high <= xyh;
    in_mode    <= md;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_report(xl, yl, xyh, md, rep);
    pending_reports.push_back(rep);
  endtask

  task automatic send_delta(input logic [11:0] dx, input logic [11:0] dy, input logic [1:0] md);
    send_burst(dx[7:0], dy[7:0], {dx[11:8], dy[11:8]}, md);
  endtask

  // drop valid, wait out every pending report, then let the pipeline drain
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MOVE_DIV:    div_move = data[7:0];
      CFG_SNIPE_DIV:   div_snipe = data[7:0];
      CFG_BASE_ORIENT: mount_ori = data[1:0];
      CFG_EXTRA_ROT:   turn_deg = data[8:0];
      CFG_INV_X:       flip_x = data[0];
      CFG_INV_Y:       flip_y = data[0];
      CFG_SCROLL_TICK: wheel_thresh = data[11:0];
      default:         ball_thresh = data[11:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [11:0] random_delta();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return 12'h000;
    if (pick <= 6) return 12'($urandom_range(80) - 40);
    if (pick <= 8) return 12'($urandom_range(4095));
    case ($urandom_range(3))
      0:       return 12'h7FF;
      1:       return 12'h800;
      2:       return 12'hFFF;
      default: return 12'h001;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] random_reg_value(input logic [2:0] idx);
    case (idx) inside
      CFG_MOVE_DIV, CFG_SNIPE_DIV:
        case ($urandom_range(4))
          0:       return 12'd1;
          1:       return 12'd255;
          2:       return 12'($urandom_range(2, 6));
          3:       return 12'($urandom_range(255));
          default: return 12'($urandom_range(4095));
        endcase
      CFG_EXTRA_ROT:
        case ($urandom_range(3))
          0:       return 12'(45 * $urandom_range(7));
          1:       return 12'($urandom_range(359));
          2:       return 12'($urandom_range(360, 511));
          default: return 12'($urandom_range(4095));
        endcase
      CFG_SCROLL_TICK, CFG_BALL_TICK:
        case ($urandom_range(3))
          0:       return 12'd0;
          1:       return 12'hFFF;
          2:       return 12'($urandom_range(1, 60));
          default: return 12'($urandom_range(4095));
        endcase
      default: return 12'($urandom_range(4095));
    endcase
  endfunction

  task automatic randomize_config(input int corner);
    settle_block();
    case (corner)
      1: begin
        write_reg(CFG_MOVE_DIV, 12'd255);
        write_reg(CFG_SNIPE_DIV, 12'd255);
        write_reg(CFG_BASE_ORIENT, CFG_W'(ORI_270));
        write_reg(CFG_EXTRA_ROT, CFG_W'(ANG_315));
        write_reg(CFG_INV_X, 12'd1);
        write_reg(CFG_INV_Y, 12'd1);
        write_reg(CFG_SCROLL_TICK, 12'hFFF);
        write_reg(CFG_BALL_TICK, 12'hFFF);
      end
      2: begin
        write_reg(CFG_MOVE_DIV, 12'd1);
        write_reg(CFG_SNIPE_DIV, 12'd1);
        write_reg(CFG_BASE_ORIENT, CFG_W'(ORI_0));
        write_reg(CFG_EXTRA_ROT, CFG_W'(ANG_0));
        write_reg(CFG_INV_X, 12'd0);
        write_reg(CFG_INV_Y, 12'd0);
        write_reg(CFG_SCROLL_TICK, 12'd0);
        write_reg(CFG_BALL_TICK, 12'd0);
      end
      default: begin
        for (int i = 0; i < 8; i++) write_reg(3'(i), random_reg_value(3'(i)));
      end
    endcase
  endtask

  // runs of one mode with random motion, salted with stray mode changes
  task automatic drive_random_bursts(input int n);
    int         sent;
    int         run;
    logic [1:0] md;
    sent = 0;
    while (sent < n) begin
      md = 2'($urandom_range(3));
      run = $urandom_range(1, 12);
      for (int k = 0; k < run && sent < n; k++) begin
        send_delta(random_delta(), random_delta(),
                   ($urandom_range(7) == 0) ? 2'($urandom_range(3)) : md);
        sent++;
      end
    end
  endtask

  task automatic test_field_extremes();
    send_delta(12'h000, 12'h000, MODE_MOVE);
    send_delta(12'h7FF, 12'h000, MODE_MOVE);
    send_delta(12'h800, 12'h7FF, MODE_MOVE);
    send_delta(12'hFFF, 12'hFFF, MODE_SNIPE);
    send_burst(8'hA5, 8'h5A, 8'h3C, MODE_SNIPE);
    send_delta(12'h000, 12'h015, MODE_SCROLL);
    send_delta(12'h00A, 12'h000, MODE_SCROLL);
    send_delta(12'h00B, 12'h000, MODE_SCROLL);
    send_delta(12'h000, 12'h00A, MODE_SCROLL);
    send_delta(12'h005, 12'h000, MODE_BALL);
    send_delta(12'h000, 12'h00F, MODE_SCROLL);
    send_delta(12'hFEB, 12'h000, MODE_BALL);
    send_delta(12'h015, 12'h000, MODE_BALL);
    send_delta(12'h000, 12'h015, MODE_BALL);
    send_delta(12'h000, 12'hFEB, MODE_BALL);
  endtask

  task automatic test_divisors();
    settle_block();
    write_reg(CFG_MOVE_DIV, 12'd7);
    write_reg(CFG_SNIPE_DIV, 12'd255);
    send_delta(12'h800, 12'h7FF, MODE_MOVE);
    send_delta(12'h7FF, 12'h800, MODE_SNIPE);
    settle_block();
    write_reg(CFG_MOVE_DIV, 12'd0);
    send_delta(12'h801, 12'h003, MODE_MOVE);
    settle_block();
    write_reg(CFG_MOVE_DIV, 12'hF03);
    send_delta(12'h801, 12'h005, MODE_MOVE);
  endtask

  task automatic rotate_once(input logic [CFG_W-1:0] deg, input logic [1:0] ori,
                             input logic inv_x_set, input logic inv_y_set,
                             input logic [11:0] dx, input logic [11:0] dy);
    settle_block();
    write_reg(CFG_EXTRA_ROT, deg);
    write_reg(CFG_BASE_ORIENT, CFG_W'(ori));
    write_reg(CFG_INV_X, CFG_W'(inv_x_set));
    write_reg(CFG_INV_Y, CFG_W'(inv_y_set));
    send_delta(dx, dy, MODE_MOVE);
  endtask

  task automatic test_rotations();
    settle_block();
    write_reg(CFG_MOVE_DIV, 12'd1);
    rotate_once(CFG_W'(ANG_45), ORI_0, 1'b0, 1'b0, 12'h800, 12'h7FF);
    rotate_once(CFG_W'(ANG_90), ORI_90, 1'b1, 1'b0, 12'h123, 12'hE51);
    rotate_once(CFG_W'(ANG_135), ORI_180, 1'b0, 1'b1, 12'h800, 12'h7FF);
    rotate_once(CFG_W'(ANG_180), ORI_270, 1'b1, 1'b1, 12'h123, 12'hE51);
    rotate_once(CFG_W'(ANG_225), ORI_0, 1'b1, 1'b0, 12'h7FF, 12'h800);
    rotate_once(CFG_W'(ANG_270), ORI_90, 1'b0, 1'b1, 12'hFFF, 12'h001);
    rotate_once(CFG_W'(ANG_315), ORI_180, 1'b0, 1'b0, 12'h001, 12'hFFF);
    rotate_once(12'd30, ORI_270, 1'b0, 1'b0, 12'h800, 12'h7FF);
    rotate_once(12'd450, ORI_0, 1'b0, 1'b0, 12'h456, 12'hBA9);
  endtask

  task automatic test_random_traffic(input int src_pct, input int sink_pct);
    for (int chunk = 0; chunk < 4; chunk++) begin
      randomize_config((chunk == 1) ? 1 : ((chunk == 2) ? 2 : 0));
      src_idle_pct = src_pct;
      sink_stall_pct = sink_pct;
      drive_random_bursts(50);
    end
  endtask

  task automatic test_back_pressure();
    randomize_config(0);
    src_idle_pct = 0;
    sink_stall_pct = 0;
    @(posedge clk);
    hold_request = HOLD_LEN;
    drive_random_bursts(30);
    settle_block();
    drive_random_bursts(10);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_field_extremes();
    test_divisors();
    test_rotations();
    test_random_traffic(0, 0);
    test_random_traffic(47, 0);
    test_random_traffic(0, 47);
    test_random_traffic(16, 16);
    test_back_pressure();
    settle_block();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### motion_delta_mode_processor_core.f
rtl/mdmp_pkg.sv
rtl/motion_delta_mode_processor_core.sv
test/tb_top.sv
